// ===== design/mlsi_pkg.sv =====
`default_nettype none
package mlsi_pkg;

	localparam int unsigned POS_W = 5;
	localparam int unsigned QUEUE_DEPTH = 4;

	typedef enum logic [2:0] {
		V_MPLS_OUT  = 3'd0,
		V_IP4_IN    = 3'd1,
		V_IP6_IN    = 3'd2,
		V_TTL_EXC   = 3'd3,
		V_NO_ROUTE  = 3'd4,
		V_BAD_LABEL = 3'd5
	} verdict_t;

	typedef enum logic [1:0] {
		K_IP4    = 2'd0,
		K_IP6    = 2'd1,
		K_TUNNEL = 2'd2,
		K_SAME   = 2'd3
	} kind_t;

	localparam logic [19:0] FIRST_UNRESERVED  = 20'd16;
	localparam logic [19:0] LBL_IP4_NULL      = 20'd0;
	localparam logic [19:0] LBL_IP6_NULL      = 20'd2;
	localparam logic [19:0] LBL_IMPLICIT_NULL = 20'd3;

	localparam logic [3:0] VER_IP4 = 4'd4;
	localparam logic [3:0] VER_IP6 = 4'd6;

	localparam logic [1:0] FAM_NONE = 2'd0;
	localparam logic [1:0] FAM_IP4  = 2'd1;
	localparam logic [1:0] FAM_IP6  = 2'd2;

	// Decision handed from the front to the back through the queue
	typedef struct packed {
		verdict_t          verdict;
		kind_t             kind;
		logic [19:0]       label;
		logic [7:0]        ttl;
		logic [15:0]       cks;
		logic [7:0]        ip_ttl;
		logic [POS_W-1:0]  removed;
		logic              via;
		logic              fix_cks;
	} decision_t;

	// Finished result as shown on the output
	typedef struct packed {
		verdict_t          verdict;
		kind_t             kind;
		logic [19:0]       label;
		logic [7:0]        ttl;
		logic [15:0]       cks;
		logic [POS_W-1:0]  removed;
		logic              via;
	} result_t;

endpackage
`default_nettype wire

// ===== design/mlsi_fifo.sv =====
`default_nettype none
module mlsi_fifo #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 4
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             wr_en,
	input  wire logic [WIDTH-1:0] wr_data,
	output logic                  full,
	input  wire logic             rd_en,
	output logic                  rd_valid,
	output logic [WIDTH-1:0]      rd_data
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);
	localparam logic [PTR_W-1:0] LAST_C = PTR_W'(DEPTH - 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_wr;
	logic             do_rd;

	assign full     = (count_q == DEPTH_C);
	assign rd_valid = (count_q != '0);
	assign rd_data  = mem_q[rd_ptr_q];
	assign do_wr    = wr_en && !full;
	assign do_rd    = rd_en && rd_valid;

	// Store a beat at the write pointer
	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == LAST_C) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == LAST_C) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

// ===== design/mlsi_front.sv =====
`default_nettype none
module mlsi_front
	import mlsi_pkg::*;
#(
	parameter int unsigned MAX_STACK_DEPTH = 8
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        accept,
	input  wire logic        first_of_packet,
	input  wire logic [19:0] label_value,
	input  wire logic [7:0]  label_ttl,
	input  wire logic        bottom_of_stack,
	input  wire logic        route_found,
	input  wire logic        swap_present,
	input  wire logic [19:0] swap_label,
	input  wire logic        via_present,
	input  wire logic [1:0]  payload_family,
	input  wire logic [3:0]  payload_version,
	input  wire logic [15:0] ip_checksum,
	input  wire logic [7:0]  ip_ttl,
	output logic             push,
	output decision_t        push_data
);

	localparam logic [POS_W-1:0] DEPTH_LIM = POS_W'(MAX_STACK_DEPTH);

	logic             decided_q;
	logic [POS_W-1:0] pos_q;
	logic             decided_eff;
	logic [POS_W-1:0] pos_eff;
	logic [POS_W-1:0] pos_inc;
	logic [7:0]       ttl_dec;
	logic [1:0]       fam;
	logic             emit;
	logic             advance;
	decision_t        dec;

	assign decided_eff = first_of_packet ? 1'b0 : decided_q;
	assign pos_eff     = first_of_packet ? '0 : pos_q;
	assign pos_inc     = pos_eff + 1'b1;
	assign ttl_dec     = label_ttl - 8'd1;

	// Resolve an unspecified family from the version nibble
	always_comb begin
		fam = payload_family;
		if (payload_family == FAM_NONE) begin
			if (payload_version == VER_IP4) begin
				fam = FAM_IP4;
			end else if (payload_version == VER_IP6) begin
				fam = FAM_IP6;
			end
		end
	end

	// Classify the entry against the packet state
	always_comb begin
		emit    = 1'b0;
		advance = 1'b0;
		dec     = '{verdict: V_BAD_LABEL, kind: K_SAME, label: '0, ttl: '0, cks: '0,
			ip_ttl: '0, removed: pos_eff, via: 1'b0, fix_cks: 1'b0};
		if (!decided_eff) begin
			emit = 1'b1;
			if (label_ttl <= 8'd1) begin
				dec.verdict = V_TTL_EXC;
			end else if (label_value < FIRST_UNRESERVED) begin
				dec.removed = pos_inc;
				if (label_value == LBL_IP4_NULL ||
						(label_value == LBL_IMPLICIT_NULL && payload_version == VER_IP4)) begin
					dec.verdict = V_IP4_IN;
					dec.kind    = K_IP4;
				end else if (label_value == LBL_IP6_NULL ||
						(label_value == LBL_IMPLICIT_NULL && payload_version == VER_IP6)) begin
					dec.verdict = V_IP6_IN;
					dec.kind    = K_IP6;
				end
			end else if (!route_found) begin
				dec.verdict = V_NO_ROUTE;
			end else if (swap_present) begin
				dec.verdict = V_MPLS_OUT;
				dec.kind    = K_TUNNEL;
				dec.label   = swap_label;
				dec.ttl     = ttl_dec;
			end else if (bottom_of_stack) begin
				if (!via_present) begin
					dec.verdict = V_NO_ROUTE;
				end else begin
					dec.removed = pos_inc;
					if (fam == FAM_IP4) begin
						dec.verdict = V_MPLS_OUT;
						dec.kind    = K_IP4;
						dec.ttl     = ttl_dec;
						dec.cks     = ip_checksum;
						dec.ip_ttl  = ip_ttl;
						dec.via     = 1'b1;
						dec.fix_cks = 1'b1;
					end else if (fam == FAM_IP6) begin
						dec.verdict = V_MPLS_OUT;
						dec.kind    = K_IP6;
						dec.ttl     = ttl_dec;
						dec.via     = 1'b1;
					end
				end
			end else begin
				// Pop a non-bottom entry; decide only when depth runs out
				advance     = 1'b1;
				dec.removed = pos_inc;
				emit        = (pos_inc >= DEPTH_LIM);
			end
		end
	end

	assign push      = accept && emit;
	assign push_data = dec;

	// Update per-packet state on each accepted beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			decided_q <= 1'b0;
			pos_q     <= '0;
		end else if (accept) begin
			decided_q <= decided_eff || emit;
			pos_q     <= advance ? pos_inc : pos_eff;
		end
	end

endmodule
`default_nettype wire

// ===== design/mlsi_back.sv =====
`default_nettype none
module mlsi_back
	import mlsi_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       q_valid,
	input  wire decision_t  q_data,
	output logic            q_pop,
	output logic            out_valid,
	input  wire logic       out_stall,
	output result_t         out_data
);

	logic        out_valid_q;
	result_t     out_q;
	logic [17:0] sum0;
	logic [16:0] sum1;
	logic [15:0] sum2;
	logic [15:0] new_cks;

	// Fold the TTL change into the IPv4 checksum, ones-complement style
	always_comb begin
		sum0 = {2'b00, ~q_data.cks} + {2'b00, ~{q_data.ip_ttl, 8'h00}}
			+ {2'b00, q_data.ttl, 8'h00};
		sum1 = {1'b0, sum0[15:0]} + {15'd0, sum0[17:16]};
		sum2 = sum1[15:0] + {15'd0, sum1[16]};
		new_cks = q_data.fix_cks ? ~sum2 : 16'd0;
	end

	assign q_pop     = q_valid && (!out_valid_q || !out_stall);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// Hold the output beat until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || !out_stall) begin
			out_valid_q <= q_valid;
		end
	end

	// Load the result payload
	always_ff @(posedge clk) begin
		if (q_pop) begin
			out_q <= '{verdict: q_data.verdict, kind: q_data.kind, label: q_data.label,
				ttl: q_data.ttl, cks: new_cks, removed: q_data.removed, via: q_data.via};
		end
	end

endmodule
`default_nettype wire

// ===== design/mpls_label_stack_input.sv =====
`default_nettype none
// Channel  | Handshake                  | Beat
// ---------+----------------------------+-------------------------------------------
// item     | item_valid / item_stall    | one label stack entry with lookup result
// result   | result_valid / result_stall| one verdict per packet
//
// One entry is taken every cycle while the decision queue has room.
// A verdict follows its deciding entry through the queue and then the
// output register; the front classifies and the back folds the checksum,
// both combinationally; a result stall can hold a verdict in the queue.
// arst_n clears the packet state, the queue and the output valid.
// item_stall rises only when the queue is full behind a stalled result.
module mpls_label_stack_input
	import mlsi_pkg::*;
#(
	parameter int unsigned MAX_STACK_DEPTH = 8
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        item_valid,
	output logic             item_stall,
	input  wire logic        first_of_packet,
	input  wire logic [19:0] label_value,
	input  wire logic [7:0]  label_ttl,
	input  wire logic        bottom_of_stack,
	input  wire logic        route_found,
	input  wire logic        swap_present,
	input  wire logic [19:0] swap_label,
	input  wire logic        via_present,
	input  wire logic [1:0]  payload_family,
	input  wire logic [3:0]  payload_version,
	input  wire logic [15:0] ip_checksum,
	input  wire logic [7:0]  ip_ttl,
	output logic             result_valid,
	input  wire logic        result_stall,
	output logic [2:0]       verdict,
	output logic [1:0]       packet_kind,
	output logic [19:0]      out_label,
	output logic [7:0]       out_ttl,
	output logic [15:0]      out_checksum,
	output logic [4:0]       labels_removed,
	output logic             use_via_hop
);

	logic      accept;
	logic      push;
	decision_t push_data;
	logic      q_full;
	logic      q_valid;
	logic      q_pop;
	decision_t q_data;
	result_t   res;

	assign item_stall = q_full;
	assign accept     = item_valid && !item_stall;

	// Classify entries and track packet state
	mlsi_front #(
		.MAX_STACK_DEPTH(MAX_STACK_DEPTH)
	) u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.accept         (accept),
		.first_of_packet(first_of_packet),
		.label_value    (label_value),
		.label_ttl      (label_ttl),
		.bottom_of_stack(bottom_of_stack),
		.route_found    (route_found),
		.swap_present   (swap_present),
		.swap_label     (swap_label),
		.via_present    (via_present),
		.payload_family (payload_family),
		.payload_version(payload_version),
		.ip_checksum    (ip_checksum),
		.ip_ttl         (ip_ttl),
		.push           (push),
		.push_data      (push_data)
	);

	// Queue decisions between front and back
	mlsi_fifo #(
		.WIDTH($bits(decision_t)),
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (push),
		.wr_data (push_data),
		.full    (q_full),
		.rd_en   (q_pop),
		.rd_valid(q_valid),
		.rd_data (q_data)
	);

	// Finish the result and drive the output register
	mlsi_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_data   (q_data),
		.q_pop    (q_pop),
		.out_valid(result_valid),
		.out_stall(result_stall),
		.out_data (res)
	);

	assign verdict        = res.verdict;
	assign packet_kind    = res.kind;
	assign out_label      = res.label;
	assign out_ttl        = res.ttl;
	assign out_checksum   = res.cks;
	assign labels_removed = res.removed;
	assign use_via_hop    = res.via;

	a_cks_only_ip4: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && out_checksum != 16'd0 |-> packet_kind == K_IP4)
		else $error("checksum written on a non-IPv4 result");

	a_via_only_pop: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && use_via_hop |->
			verdict == V_MPLS_OUT && (packet_kind == K_IP4 || packet_kind == K_IP6))
		else $error("via hop flagged outside a bottom pop");

	a_depth_bound: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> labels_removed <= 5'(MAX_STACK_DEPTH))
		else $error("more entries removed than stack depth allows");

	a_ttl_exc_clean: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && verdict == V_TTL_EXC |-> out_label == 20'd0 && out_ttl == 8'd0)
		else $error("ttl exceeded verdict carries rewrite fields");

endmodule
`default_nettype wire

// ===== bench/mpls_label_stack_input_test.sv =====
module mpls_label_stack_input_test;
	import mlsi_pkg::*;

	localparam int STACK_LIMIT = 8;
	localparam int QUIET_LIMIT = 4000;
	localparam int SHOWN_MISMATCHES = 10;
	localparam int HOLDOFF_CYCLES = 300;
	localparam int SETTLE_CYCLES = 20;
	localparam logic [1:0] FAM_BOGUS = 2'd3;

	// One label stack entry with its lookup result and payload peek
	typedef struct packed {
		logic        first;
		logic [19:0] label;
		logic [7:0]  lttl;
		logic        bos;
		logic        found;
		logic        swap;
		logic [19:0] swap_label;
		logic        via;
		logic [1:0]  family;
		logic [3:0]  version;
		logic [15:0] cks;
		logic [7:0]  ipttl;
	} entry_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        item_valid = 1'b0;
	logic        item_stall;
	logic        first_of_packet = 1'b0;
	logic [19:0] label_value = '0;
	logic [7:0]  label_ttl = '0;
	logic        bottom_of_stack = 1'b0;
	logic        route_found = 1'b0;
	logic        swap_present = 1'b0;
	logic [19:0] swap_label = '0;
	logic        via_present = 1'b0;
	logic [1:0]  payload_family = '0;
	logic [3:0]  payload_version = '0;
	logic [15:0] ip_checksum = '0;
	logic [7:0]  ip_ttl = '0;
	logic        result_valid;
	logic        result_stall = 1'b0;
	logic [2:0]  verdict;
	logic [1:0]  packet_kind;
	logic [19:0] out_label;
	logic [7:0]  out_ttl;
	logic [15:0] out_checksum;
	logic [4:0]  labels_removed;
	logic        use_via_hop;

	// Predicted verdicts in packet order, and the predictor's packet state
	result_t     pending_verdicts[$];
	bit          pkt_decided = 1'b0;
	logic [4:0]  pkt_popped = '0;

	int entries_used = 0;
	int mismatches = 0;
	int idle_pct = 0;
	int stall_pct = 0;
	int holdoff_request = 0;
	int holdoff_left = 0;
	int quiet_cycles = 0;

	always #1 clk = ~clk;

	mpls_label_stack_input #(.MAX_STACK_DEPTH(STACK_LIMIT)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.first_of_packet(first_of_packet),
		.label_value(label_value),
		.label_ttl(label_ttl),
		.bottom_of_stack(bottom_of_stack),
		.route_found(route_found),
		.swap_present(swap_present),
		.swap_label(swap_label),
		.via_present(via_present),
		.payload_family(payload_family),
		.payload_version(payload_version),
		.ip_checksum(ip_checksum),
		.ip_ttl(ip_ttl),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.verdict(verdict),
		.packet_kind(packet_kind),
		.out_label(out_label),
		.out_ttl(out_ttl),
		.out_checksum(out_checksum),
		.labels_removed(labels_removed),
		.use_via_hop(use_via_hop)
	);

	function automatic result_t verdict_rec(verdict_t v, kind_t k, logic [19:0] lbl,
			logic [7:0] ttl, logic [15:0] cks, logic [4:0] removed, logic via);
		result_t r;
		r.verdict = v;
		r.kind = k;
		r.label = lbl;
		r.ttl = ttl;
		r.cks = cks;
		r.removed = removed;
		r.via = via;
		return r;
	endfunction

	// Patch the IPv4 checksum for a TTL rewrite, one's complement style
	function automatic logic [15:0] ttl_fixed_checksum(logic [15:0] cks, logic [7:0] old_ttl,
			logic [7:0] new_ttl);
		logic [15:0] inv_cks;
		logic [15:0] inv_old;
		logic [17:0] sum;
		inv_cks = ~cks;
		inv_old = ~{old_ttl, 8'h00};
		sum = {2'b00, inv_cks} + {2'b00, inv_old} + {2'b00, new_ttl, 8'h00};
		sum = {2'b00, sum[15:0]} + {16'h0000, sum[17:16]};
		sum = {2'b00, sum[15:0]} + {16'h0000, sum[17:16]};
		return ~sum[15:0];
	endfunction

	// Walk one entry through the packet state; emitted tells if a verdict falls out
	task automatic classify_entry(input entry_t e, output bit emitted, output result_t r);
		logic [4:0] pos;
		logic [7:0] ttl;
		logic [1:0] af;
		emitted = 1'b0;
		r = '0;
		if (e.first) begin
			pkt_decided = 1'b0;
			pkt_popped = '0;
		end
		if (pkt_decided)
			return;
		entries_used++;
		pos = pkt_popped;
		ttl = e.lttl - 8'd1;
		emitted = 1'b1;
		if (e.lttl <= 8'd1) begin
			r = verdict_rec(V_TTL_EXC, K_SAME, '0, '0, '0, pos, 1'b0);
		end else if (e.label < FIRST_UNRESERVED) begin
			// reserved labels pop without any TTL write
			if (e.label == LBL_IP4_NULL
					|| (e.label == LBL_IMPLICIT_NULL && e.version == VER_IP4))
				r = verdict_rec(V_IP4_IN, K_IP4, '0, '0, '0, pos + 5'd1, 1'b0);
			else if (e.label == LBL_IP6_NULL
					|| (e.label == LBL_IMPLICIT_NULL && e.version == VER_IP6))
				r = verdict_rec(V_IP6_IN, K_IP6, '0, '0, '0, pos + 5'd1, 1'b0);
			else
				r = verdict_rec(V_BAD_LABEL, K_SAME, '0, '0, '0, pos + 5'd1, 1'b0);
		end else if (!e.found) begin
			r = verdict_rec(V_NO_ROUTE, K_SAME, '0, '0, '0, pos, 1'b0);
		end else if (e.swap) begin
			r = verdict_rec(V_MPLS_OUT, K_TUNNEL, e.swap_label, ttl, '0, pos, 1'b0);
		end else if (e.bos) begin
			af = e.family;
			if (af == FAM_NONE) begin
				if (e.version == VER_IP4)
					af = FAM_IP4;
				else if (e.version == VER_IP6)
					af = FAM_IP6;
			end
			if (!e.via)
				r = verdict_rec(V_NO_ROUTE, K_SAME, '0, '0, '0, pos, 1'b0);
			else if (af == FAM_IP4)
				r = verdict_rec(V_MPLS_OUT, K_IP4, '0, ttl,
					ttl_fixed_checksum(e.cks, e.ipttl, ttl), pos + 5'd1, 1'b1);
			else if (af == FAM_IP6)
				r = verdict_rec(V_MPLS_OUT, K_IP6, '0, ttl, '0, pos + 5'd1, 1'b1);
			else
				r = verdict_rec(V_BAD_LABEL, K_SAME, '0, '0, '0, pos + 5'd1, 1'b0);
		end else begin
			// pop a non-bottom entry; give up once the stack runs too deep
			pos = pos + 5'd1;
			pkt_popped = pos;
			if (pos >= STACK_LIMIT)
				r = verdict_rec(V_BAD_LABEL, K_SAME, '0, '0, '0, pos, 1'b0);
			else
				emitted = 1'b0;
		end
		if (emitted)
			pkt_decided = 1'b1;
	endtask

	// Offer one beat, hold it until taken, then predict its verdict
	task automatic send_entry(input entry_t e);
		bit emitted;
		result_t r;
		@(negedge clk);
		while ($urandom_range(99) < idle_pct) begin
			item_valid <= 1'b0;
			@(negedge clk);
		end
		item_valid <= 1'b1;
		first_of_packet <= e.first;
		label_value <= e.label;
		label_ttl <= e.lttl;
		bottom_of_stack <= e.bos;
		route_found <= e.found;
		swap_present <= e.swap;
		swap_label <= e.swap_label;
		via_present <= e.via;
		payload_family <= e.family;
		payload_version <= e.version;
		ip_checksum <= e.cks;
		ip_ttl <= e.ipttl;
		do @(posedge clk); while (item_stall);
		classify_entry(e, emitted, r);
		if (emitted)
			pending_verdicts.push_back(r);
	endtask

	// Drop valid and wait for every predicted verdict to come out
	task automatic drain_verdicts();
		@(negedge clk);
		item_valid <= 1'b0;
		while (pending_verdicts.size() != 0)
			@(posedge clk);
	endtask

	function automatic entry_t clean_entry();
		entry_t e;
		e.first = 1'b1;
		e.label = 20'd100;
		e.lttl = 8'd64;
		e.bos = 1'b1;
		e.found = 1'b1;
		e.swap = 1'b0;
		e.swap_label = 20'd0;
		e.via = 1'b1;
		e.family = FAM_IP4;
		e.version = VER_IP4;
		e.cks = 16'h1234;
		e.ipttl = 8'd64;
		return e;
	endfunction

	function automatic entry_t noise_entry();
		logic [95:0] bits;
		bits = {$urandom(), $urandom(), $urandom()};
		return bits[$bits(entry_t)-1:0];
	endfunction

	// Well-formed packet: a run of plain pops, a deciding entry, maybe one stray beat after
	task automatic send_packet();
		int pops;
		entry_t e;
		pops = ($urandom_range(9) < 8) ? $urandom_range(0, 2) : $urandom_range(3, STACK_LIMIT + 1);
		for (int i = 0; i < pops; i++) begin
			e = noise_entry();
			e.first = (i == 0);
			e.label = 20'($urandom_range(16, 20'hFFFFF));
			e.lttl = 8'($urandom_range(2, 255));
			e.bos = 1'b0;
			e.found = 1'b1;
			e.swap = 1'b0;
			send_entry(e);
		end
		e = noise_entry();
		e.first = (pops == 0);
		case ($urandom_range(9))
			0: e.label = 20'($urandom_range(0, 4));
			1: e.label = 20'($urandom_range(0, 15));
			default: ;
		endcase
		if ($urandom_range(9) == 0)
			e.lttl = 8'($urandom_range(0, 1));
		e.found = ($urandom_range(9) != 0);
		e.via = ($urandom_range(9) != 0);
		if ($urandom_range(1) == 1)
			e.version = ($urandom_range(1) == 1) ? VER_IP4 : VER_IP6;
		send_entry(e);
		if ($urandom_range(4) == 0) begin
			e = noise_entry();
			e.first = 1'b0;
			send_entry(e);
		end
	endtask

	task automatic run_traffic(input int idle, input int stall, input int count);
		int target;
		idle_pct = idle;
		stall_pct = stall;
		target = entries_used + count;
		while (entries_used < target) begin
			if ($urandom_range(9) < 8)
				send_packet();
			else
				send_entry(noise_entry());
		end
		drain_verdicts();
	endtask

	// First beat after reset carries no mark and must open a packet anyway
	task automatic test_unmarked_start();
		entry_t e;
		e = clean_entry();
		e.first = 1'b0;
		e.label = 20'hFFFFF;
		e.lttl = 8'hFF;
		e.bos = 1'b0;
		e.swap = 1'b1;
		e.swap_label = 20'hFFFFF;
		send_entry(e);
	endtask

	task automatic test_ttl_limits();
		entry_t e;
		e = clean_entry();
		e.lttl = 8'd0;
		send_entry(e);
		e.lttl = 8'd1;
		e.label = LBL_IP4_NULL;
		send_entry(e);
	endtask

	task automatic test_reserved_labels();
		entry_t e;
		e = clean_entry();
		e.label = LBL_IP4_NULL;
		e.version = VER_IP6;
		send_entry(e);
		e.label = LBL_IP6_NULL;
		e.bos = 1'b0;
		send_entry(e);
		e.label = LBL_IMPLICIT_NULL;
		e.version = VER_IP4;
		send_entry(e);
		e.version = VER_IP6;
		send_entry(e);
		e.version = 4'd9;
		send_entry(e);
		e.label = FIRST_UNRESERVED - 20'd1;
		e.version = VER_IP4;
		send_entry(e);
	endtask

	task automatic test_lookup_outcomes();
		entry_t e;
		e = clean_entry();
		e.found = 1'b0;
		send_entry(e);
		e = clean_entry();
		e.swap = 1'b1;
		e.swap_label = 20'd0;
		e.lttl = 8'd2;
		send_entry(e);
		e = clean_entry();
		e.via = 1'b0;
		send_entry(e);
	endtask

	task automatic test_bottom_pop();
		entry_t e;
		e = clean_entry();
		e.lttl = 8'd2;
		e.cks = 16'h0000;
		e.ipttl = 8'hFF;
		send_entry(e);
		e.lttl = 8'hFF;
		e.cks = 16'hFFFF;
		e.ipttl = 8'h00;
		send_entry(e);
		e.family = FAM_IP6;
		e.version = 4'd0;
		send_entry(e);
		e.family = FAM_NONE;
		e.version = VER_IP4;
		send_entry(e);
		e.version = VER_IP6;
		send_entry(e);
		e.family = FAM_BOGUS;
		send_entry(e);
	endtask

	// New mark mid-packet, then pop until the depth limit, then a stray beat
	task automatic test_stack_depth();
		entry_t e;
		e = clean_entry();
		e.bos = 1'b0;
		send_entry(e);
		for (int i = 0; i < STACK_LIMIT; i++) begin
			e.first = (i == 0);
			e.label = 20'd16 + 20'(i);
			send_entry(e);
		end
		e.first = 1'b0;
		e.swap = 1'b1;
		send_entry(e);
	endtask

	// Hold results back long enough that the block must stall its input
	task automatic test_long_holdoff();
		int target;
		idle_pct = 0;
		stall_pct = 0;
		holdoff_request = HOLDOFF_CYCLES;
		target = entries_used + 100;
		while (entries_used < target)
			send_packet();
		drain_verdicts();
	endtask

	// Sender stops mid-stream until everything is out, then resumes
	task automatic test_drain_pause();
		idle_pct = 12;
		stall_pct = 12;
		for (int i = 0; i < 20; i++)
			send_packet();
		drain_verdicts();
		for (int i = 0; i < 20; i++)
			send_packet();
		drain_verdicts();
	endtask

	task automatic test_random_traffic();
		run_traffic(0, 0, 250);
		run_traffic(75, 0, 250);
		run_traffic(0, 75, 250);
		run_traffic(12, 12, 200);
	endtask

	// Drive receiver stall: long hold-off when asked, else random
	always @(negedge clk) begin
		if (holdoff_request != 0) begin
			holdoff_left = holdoff_request;
			holdoff_request = 0;
		end
		if (holdoff_left != 0) begin
			result_stall <= 1'b1;
			holdoff_left--;
		end else begin
			result_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	// Compare each result beat against the oldest prediction
	always @(posedge clk) begin : check_verdicts
		result_t got;
		result_t want;
		got = {verdict, packet_kind, out_label, out_ttl, out_checksum, labels_removed,
			use_via_hop};
		if (arst_n && result_valid && !result_stall) begin
			if (pending_verdicts.size() == 0) begin
				mismatches++;
				if (mismatches <= SHOWN_MISMATCHES)
					$display("unexpected verdict beat: v=%0d k=%0d lbl=%h ttl=%0d cks=%h rm=%0d via=%0d",
						got.verdict, got.kind, got.label, got.ttl, got.cks, got.removed, got.via);
			end else begin
				want = pending_verdicts.pop_front();
				if (got.verdict !== want.verdict || got.kind !== want.kind
						|| got.label !== want.label || got.ttl !== want.ttl
						|| got.cks !== want.cks || got.removed !== want.removed
						|| got.via !== want.via) begin
					mismatches++;
					if (mismatches <= SHOWN_MISMATCHES) begin
						$display("verdict mismatch: want v=%0d k=%0d lbl=%h ttl=%0d cks=%h rm=%0d via=%0d",
							want.verdict, want.kind, want.label, want.ttl, want.cks,
							want.removed, want.via);
						$display("                  got  v=%0d k=%0d lbl=%h ttl=%0d cks=%h rm=%0d via=%0d",
							got.verdict, got.kind, got.label, got.ttl, got.cks,
							got.removed, got.via);
					end
				end
			end
		end
	end

	// Abort when neither side has moved a beat for too long
	always @(posedge clk) begin
		if ((item_valid && !item_stall) || (result_valid && !result_stall))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles == QUIET_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_unmarked_start();
		test_ttl_limits();
		test_reserved_labels();
		test_lookup_outcomes();
		test_bottom_pop();
		test_stack_depth();
		drain_verdicts();
		test_random_traffic();
		test_long_holdoff();
		test_drain_pause();
		drain_verdicts();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
